// ----- rtl/rise_pkg.sv -----
// ----------------------------------------------------------------------------
// rise_pkg: shared constants for the integer subset executor
// Opcodes, function codes, syscall codes, status and print codes, divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none
package rise_pkg;
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_MUL   = 6'd28;

  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_MFHI = 6'd16;
  localparam logic [5:0] FN_MFLO = 6'd18;
  localparam logic [5:0] FN_MULT = 6'd24;
  localparam logic [5:0] FN_DIV  = 6'd26;
  localparam logic [5:0] FN_SYSC = 6'd12;

  localparam logic [31:0] SYS_PINT  = 32'd1;
  localparam logic [31:0] SYS_PCHR  = 32'd11;
  localparam logic [31:0] SYS_EXIT  = 32'd10;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EXIT   = 3'd1;
  localparam logic [2:0] ST_BRANCH = 3'd2;
  localparam logic [2:0] ST_SYSC   = 3'd3;
  localparam logic [2:0] ST_INVAL  = 3'd4;
  localparam logic [2:0] ST_END    = 3'd5;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_INT  = 2'd1;
  localparam logic [1:0] PK_CHR  = 2'd2;

  // Divider handshake
  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/risc_integer_subset_executor.sv -----
// ----------------------------------------------------------------------------
// risc_integer_subset_executor: integer subset instruction executor
// Executes one instruction word per item against a register file memory.
// ----------------------------------------------------------------------------
// Each item is one instruction word fetched at the stored program counter; one
// result item follows with the next fetch address, status and print data. The
// 32 general registers live in a synchronous memory read at two ports; an item
// steps through accept, register read, execute/write back and result, mult and
// mul add a step for the registered product, and a div by a nonzero divisor
// waits for the bit-serial divider. The register file is cleared by a pass over
// all 32 registers after reset, during which no item is accepted.
`default_nettype none
module risc_integer_subset_executor
  import rise_pkg::*;
#(
  parameter int MAX_PROGRAM = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] instr_word_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      next_pc_o,
  output logic [2:0]       status_o,
  output logic [1:0]       print_kind_o,
  output logic signed [31:0] print_value_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_program_length_i
);
  localparam int LenW = $clog2(MAX_PROGRAM + 1);
  localparam int PcW  = $clog2(MAX_PROGRAM);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_READ = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] rf_mem [32];
  logic [31:0] rd_a_q, rd_b_q;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [4:0]  clr_q;
  logic [4:0]  ra_addr, rb_addr;

  logic [31:0] ir_q, hi_q, lo_q;
  logic [PcW:0] pc_q;
  logic        halted_q;
  logic [12:0] plen_q;
  logic [LenW-1:0] len;
  logic [63:0] prod_q;
  logic signed [63:0] mul_full;
  logic        live;

  logic [11:0] o_pc_q;
  logic [2:0]  o_st_q;
  logic [1:0]  o_pk_q;
  logic [31:0] o_pv_q;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd;
  logic [31:0] imm, simm;
  assign op   = ir_q[31:26];
  assign rs   = ir_q[25:21];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign fn   = ir_q[5:0];
  assign imm  = {16'd0, ir_q[15:0]};
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};

  // Clamp program length to the program size
  assign len = (32'(plen_q) > 32'(MAX_PROGRAM)) ? LenW'(MAX_PROGRAM) : LenW'(plen_q);

  // Execute only while not halted and the counter is inside the program
  assign live = !halted_q && (pc_q < (PcW+1)'(len));

  // Syscall reads v0 and a0 through the same ports
  always_comb begin
    ra_addr = instr_word_i[25:21];
    rb_addr = instr_word_i[20:16];
    if (instr_word_i[31:26] == OP_RTYPE && instr_word_i[5:0] == FN_SYSC) begin
      ra_addr = 5'd2;
      rb_addr = 5'd4;
    end
  end

  // Register file memory
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    if (state_q == S_IDLE && in_valid) begin
      rd_a_q <= rf_mem[ra_addr];
      rd_b_q <= rf_mem[rb_addr];
    end
  end

  assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLR);
  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);

  logic [31:0] a, b;
  assign a = (rs == 5'd0 && !(op == OP_RTYPE && fn == FN_SYSC)) ? 32'd0 : rd_a_q;
  assign b = (rt == 5'd0 && !(op == OP_RTYPE && fn == FN_SYSC)) ? 32'd0 : rd_b_q;

  // Full signed product; its low word serves mul as well
  assign mul_full = $signed(a) * $signed(b);

  assign dreq.start    = (state_q == S_EXEC) && live && op == OP_RTYPE && fn == FN_DIV &&
                         b != 32'd0;
  assign dreq.dividend = a;
  assign dreq.divisor  = b;

  rise_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Execute: result, write back, next pc
  logic        wb_en, hilo_mul, hilo_div, stop, take;
  logic [4:0]  wb_idx;
  logic [31:0] wb_val, pval;
  logic [2:0]  st;
  logic [1:0]  pk;
  logic [PcW:0] nxt;
  logic signed [17:0] tgt;
  logic        pc_end;

  always_comb begin
    wb_en = 1'b0; wb_idx = rd; wb_val = '0;
    hilo_mul = 1'b0; hilo_div = 1'b0;
    stop = 1'b0; st = ST_OK; pk = PK_NONE; pval = '0;
    take = 1'b0;
    tgt = $signed(18'(pc_q)) + 18'($signed(ir_q[15:0]));
    nxt = pc_q + 1'b1;
    priority if (op == OP_BEQ || op == OP_BNE) begin
      take = (op == OP_BEQ) ? (a == b) : (a != b);
      if (take) begin
        if (tgt < 0 || tgt >= $signed(18'(len))) begin
          st = ST_BRANCH;
          stop = 1'b1;
        end else begin
          nxt = tgt[PcW:0];
        end
      end
    end else if (op == OP_RTYPE) begin
      unique case (fn)
        FN_ADD:  begin wb_en = 1'b1; wb_val = a + b; end
        FN_SUB:  begin wb_en = 1'b1; wb_val = a - b; end
        FN_SLT:  begin wb_en = 1'b1; wb_val = {31'd0, $signed(a) < $signed(b)}; end
        FN_MFHI: begin wb_en = 1'b1; wb_val = hi_q; end
        FN_MFLO: begin wb_en = 1'b1; wb_val = lo_q; end
        FN_MULT: hilo_mul = 1'b1;
        FN_DIV:  hilo_div = (b != 32'd0);
        FN_SYSC: begin
          priority if (a == SYS_PINT) begin
            pk = PK_INT; pval = b;
          end else if (a == SYS_PCHR) begin
            pk = PK_CHR; pval = {24'd0, b[7:0]};
          end else if (a == SYS_EXIT) begin
            st = ST_EXIT; stop = 1'b1;
          end else begin
            st = ST_SYSC; pval = a; stop = 1'b1;
          end
        end
        default: st = ST_INVAL;
      endcase
    end else if (op == OP_ADDI) begin
      wb_en = 1'b1; wb_idx = rt; wb_val = a + simm;
    end else if (op == OP_ORI) begin
      wb_en = 1'b1; wb_idx = rt; wb_val = a | imm;
    end else if (op == OP_LUI) begin
      wb_en = 1'b1; wb_idx = rt; wb_val = {ir_q[15:0], 16'd0};
    end else begin
      wb_en = 1'b0;
    end
    if (stop) nxt = pc_q;
    pc_end = !stop && (nxt >= (PcW+1)'(len));
  end

  // Write port: clear pass, ALU result or mul low word
  always_comb begin
    rf_we = 1'b0; rf_waddr = wb_idx; rf_wdata = wb_val;
    if (state_q == S_CLR) begin
      rf_we = 1'b1; rf_waddr = clr_q; rf_wdata = '0;
    end else if (state_q == S_EXEC && live && wb_en && op != OP_MUL) begin
      rf_we = 1'b1;
    end else if (state_q == S_MUL && op == OP_MUL) begin
      rf_we = 1'b1; rf_waddr = rd; rf_wdata = prod_q[31:0];
    end
    if (state_q != S_CLR && rf_waddr == 5'd0) rf_we = 1'b0;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == 5'd31) state_d = S_IDLE;
      S_IDLE: if (in_valid) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (!live) state_d = S_OUT;
        else if (op == OP_MUL || hilo_mul) state_d = S_MUL;
        else if (hilo_div) state_d = S_DIV;
        else state_d = S_OUT;
      end
      S_MUL:  state_d = S_OUT;
      S_DIV:  if (drsp.done) state_d = S_OUT;
      S_OUT:  if (!out_stall) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      pc_q     <= '0;
      halted_q <= 1'b0;
      hi_q     <= '0;
      lo_q     <= '0;
      plen_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 5'd1;
      if (cfg_valid && cfg_ready) plen_q <= cfg_program_length_i;
      if (state_q == S_EXEC) begin
        if (!live) begin
          halted_q <= 1'b1;
        end else begin
          if (stop || pc_end) halted_q <= 1'b1;
          if (!stop) pc_q <= nxt;
        end
      end
      if (state_q == S_MUL && hilo_mul) begin
        hi_q <= prod_q[63:32];
        lo_q <= prod_q[31:0];
      end
      if (state_q == S_DIV && drsp.done) begin
        hi_q <= drsp.rem;
        lo_q <= drsp.quot;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid) ir_q <= instr_word_i;
    if (state_q == S_EXEC) begin
      prod_q <= mul_full;
      if (!live) begin
        o_pc_q <= 12'(pc_q);
        o_st_q <= ST_END;
        o_pk_q <= PK_NONE;
        o_pv_q <= '0;
      end else begin
        o_pc_q <= 12'(nxt);
        o_st_q <= pc_end ? ST_END : st;
        o_pk_q <= pk;
        o_pv_q <= pval;
      end
    end
  end

  assign next_pc_o     = o_pc_q;
  assign status_o      = o_st_q;
  assign print_kind_o  = o_pk_q;
  assign print_value_o = o_pv_q;

  // Checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall) else $error("item accepted while busy");
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(in_valid && !in_stall)) else $error("overlap of items");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted_q) |-> halted_q) else $error("halt cleared");
  a_div_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == S_DIV)) else $error("stray divider result");
endmodule
`default_nettype wire

// ----- rtl/rise_div.sv -----
// ----------------------------------------------------------------------------
// rise_div: signed 32-bit iterative divider
// Restoring division one quotient bit per cycle; quotient truncates to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module rise_div
  import rise_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] quo_q, div_q;
  logic [32:0] rem_q;
  logic        negq_q, negr_q;
  logic        done_q;
  logic [32:0] trial;
  logic [31:0] absa, absb;

  assign absa  = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
  assign absb  = req_i.divisor[31] ? (32'd0 - req_i.divisor) : req_i.divisor;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, div_q};

  // Iterate one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q  <= absa;
      div_q  <= absb;
      rem_q  <= '0;
      negq_q <= req_i.dividend[31] ^ req_i.divisor[31];
      negr_q <= req_i.dividend[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = negq_q ? (32'd0 - quo_q) : quo_q;
  assign rsp_o.rem  = negr_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
endmodule
`default_nettype wire
